// ===== sv/pra_pkg.sv =====
// ----------------------------------------------------------------------------
// pra_pkg: shared types and constants of the point rotation pipeline
// widths, cordic constants, arctangent table and degree-to-phase tables
// ----------------------------------------------------------------------------
package pra_pkg;

  localparam int unsigned DATA_W    = 32;  // coordinate and angle fields
  localparam int unsigned DIFF_W    = 33;  // point minus center, exact
  localparam int unsigned CORDIC_W  = 34;  // cordic x, y and z datapath
  localparam int unsigned TRIG_W    = 32;  // clamped cos and sin, q2.30
  localparam int unsigned TRIG_FRAC = 30;
  localparam int unsigned PHASE_W   = 32;  // 2^32 is one full turn
  localparam int unsigned ATAN_N    = 32;

  // 360 degrees split as 8 * 45: the factor of 8 is a shift, 45 is divided out
  localparam int unsigned PHASE_DIV   = 45;
  localparam int unsigned PHASE_ROUND = 22;  // half of 360, over 8
  localparam int unsigned QV_W        = 29;
  localparam int unsigned RV_W        = 6;
  localparam int unsigned L8_W        = 30;
  localparam int unsigned RCP2_W      = 25;

  // floor(2^30 / 45), quotient estimate at most one low for values below 2^30
  localparam logic [RCP2_W-1:0] RECIP45_Q30 = RCP2_W'((64'd1 << 30) / 64'(PHASE_DIV));

  localparam logic signed [CORDIC_W-1:0] GAIN_Q30 = 34'sh0_26DD_3B6A;
  localparam logic signed [CORDIC_W-1:0] ONE_Q30  = 34'sh0_4000_0000;

  localparam logic signed [PHASE_W-1:0] QUARTER_POS = 32'sh4000_0000;
  localparam logic signed [PHASE_W-1:0] QUARTER_NEG = 32'shC000_0000;

  localparam logic [31:0] ATAN_PHASE [ATAN_N] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
    32'h00000001, 32'h00000000
  };

  typedef logic [PHASE_DIV-1:0][QV_W-1:0] qv_tab_t;
  typedef logic [PHASE_DIV-1:0][RV_W-1:0] rv_tab_t;

  // quotient and remainder of v * 2^29 / 45, one entry per residue v
  function automatic qv_tab_t build_qv_tab();
    qv_tab_t tab;
    for (int i = 0; i < PHASE_DIV; i++) begin
      tab[i] = QV_W'((64'(i) << 29) / 64'(PHASE_DIV));
    end
    return tab;
  endfunction

  function automatic rv_tab_t build_rv_tab();
    rv_tab_t tab;
    for (int i = 0; i < PHASE_DIV; i++) begin
      tab[i] = RV_W'((64'(i) << 29) % 64'(PHASE_DIV));
    end
    return tab;
  endfunction

  localparam qv_tab_t QV_TAB = build_qv_tab();
  localparam rv_tab_t RV_TAB = build_rv_tab();

  // offset data that rides alongside the angle path
  typedef struct packed {
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    logic signed [DATA_W-1:0] cx;
    logic signed [DATA_W-1:0] cy;
  } side_t;

  typedef struct packed {
    logic valid;
    logic neg;
  } ctl_t;

endpackage

// ===== sv/pra_phase.sv =====
// ----------------------------------------------------------------------------
// pra_phase: degrees to phase conversion
// seven stage pipeline, q16.16 degrees to a folded 32-bit phase
// ----------------------------------------------------------------------------
module pra_phase import pra_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  logic signed [DATA_W-1:0]   angle_deg_i,
  input  side_t                      side_i,
  output ctl_t                       ctl_o,
  output logic signed [CORDIC_W-1:0] z_o,
  output side_t                      side_o
);

  localparam int unsigned HI_W  = DATA_W - FRAC_BITS;
  localparam int unsigned HU_W  = 37 - FRAC_BITS;
  localparam int unsigned RCP_W = HU_W - 5;
  localparam int unsigned PRD_W = HU_W + RCP_W;
  localparam logic [HU_W-1:0]  HI_BIAS   = HU_W'(64'(PHASE_DIV) << (31 - FRAC_BITS));
  localparam logic [RCP_W-1:0] RECIP_HI  = RCP_W'((64'd1 << HU_W) / 64'(PHASE_DIV));
  localparam int unsigned      PRD2_W    = L8_W + RCP2_W;

  // stage a: biased integer degrees
  logic                     a_valid_q;
  logic [HU_W-1:0]          a_hu_q;
  logic [FRAC_BITS-1:0]     a_lo_q;
  side_t                    a_side_q;
  logic signed [HI_W-1:0]   a_hi;
  // stage b: reciprocal product
  logic                     b_valid_q;
  logic [PRD_W-1:0]         b_prod_q;
  logic [HU_W-1:0]          b_hu_q;
  logic [FRAC_BITS-1:0]     b_lo_q;
  side_t                    b_side_q;
  // stage c: residue mod 45 and low quotient bits
  logic                     c_valid_q;
  logic [RV_W-1:0]          c_v_q;
  logic [2:0]               c_u_q;
  logic [L8_W-1:0]          c_l8_q;
  side_t                    c_side_q;
  logic [RCP_W-1:0]         c_est;
  logic [HU_W-1:0]          c_rem;
  logic [6:0]               c_rem7;
  logic                     c_fix;
  // stage d: table lookup
  logic                     d_valid_q;
  logic [QV_W-1:0]          d_qv_q;
  logic [L8_W-1:0]          d_x_q;
  logic [2:0]               d_u_q;
  side_t                    d_side_q;
  // stage e: second reciprocal product
  logic                     e_valid_q;
  logic [PRD2_W-1:0]        e_prod_q;
  logic [L8_W-1:0]          e_x_q;
  logic [QV_W-1:0]          e_qv_q;
  logic [2:0]               e_u_q;
  side_t                    e_side_q;
  // stage f: phase
  logic                     f_valid_q;
  logic [PHASE_W-1:0]       f_phase_q;
  side_t                    f_side_q;
  logic [RCP2_W-1:0]        f_est;
  logic [L8_W-1:0]          f_rem;
  logic [6:0]               f_rem7;
  logic [RCP2_W-1:0]        f_q2;
  // stage g: quadrant fold
  logic signed [PHASE_W-1:0] g_p;
  logic                      g_neg;
  logic signed [PHASE_W-1:0] g_z;
  ctl_t                      g_ctl_q;
  logic signed [CORDIC_W-1:0] g_z_q;
  side_t                     g_side_q;

  assign a_hi = angle_deg_i[DATA_W-1:FRAC_BITS];

  assign c_est  = b_prod_q[PRD_W-1:HU_W];
  assign c_rem  = b_hu_q - HU_W'(c_est) * HU_W'(PHASE_DIV);
  assign c_rem7 = c_rem[6:0];
  assign c_fix  = (c_rem7 >= 7'(PHASE_DIV));

  assign f_est  = e_prod_q[PRD2_W-1:L8_W];
  assign f_rem  = e_x_q - L8_W'(f_est) * L8_W'(PHASE_DIV);
  assign f_rem7 = f_rem[6:0];
  assign f_q2   = f_est + RCP2_W'(f_rem7 >= 7'(PHASE_DIV));

  // half a turn off when beyond a quarter turn either way
  assign g_p   = f_phase_q;
  assign g_neg = (g_p > QUARTER_POS) || (g_p < QUARTER_NEG);
  assign g_z   = g_neg ? {~g_p[PHASE_W-1], g_p[PHASE_W-2:0]} : g_p;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
      d_valid_q <= 1'b0;
      e_valid_q <= 1'b0;
      f_valid_q <= 1'b0;
      g_ctl_q   <= '0;
    end else if (en_i) begin
      a_valid_q <= valid_i;
      b_valid_q <= a_valid_q;
      c_valid_q <= b_valid_q;
      d_valid_q <= c_valid_q;
      e_valid_q <= d_valid_q;
      f_valid_q <= e_valid_q;
      g_ctl_q   <= '{valid: f_valid_q, neg: g_neg};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_hu_q   <= HU_W'(a_hi) + HI_BIAS;
      a_lo_q   <= angle_deg_i[FRAC_BITS-1:0];
      a_side_q <= side_i;

      b_prod_q <= PRD_W'(a_hu_q) * PRD_W'(RECIP_HI);
      b_hu_q   <= a_hu_q;
      b_lo_q   <= a_lo_q;
      b_side_q <= a_side_q;

      c_v_q    <= c_fix ? RV_W'(c_rem7 - 7'(PHASE_DIV)) : RV_W'(c_rem7);
      c_u_q    <= c_est[2:0] + 3'(c_fix);
      c_l8_q   <= (L8_W'(b_lo_q) << (29 - FRAC_BITS)) + L8_W'(PHASE_ROUND);
      c_side_q <= b_side_q;

      d_qv_q   <= QV_TAB[c_v_q];
      d_x_q    <= c_l8_q + L8_W'(RV_TAB[c_v_q]);
      d_u_q    <= c_u_q;
      d_side_q <= c_side_q;

      e_prod_q <= PRD2_W'(d_x_q) * PRD2_W'(RECIP45_Q30);
      e_x_q    <= d_x_q;
      e_qv_q   <= d_qv_q;
      e_u_q    <= d_u_q;
      e_side_q <= d_side_q;

      f_phase_q <= {e_u_q, {QV_W{1'b0}}} + PHASE_W'(e_qv_q) + PHASE_W'(f_q2);
      f_side_q  <= e_side_q;

      g_z_q    <= CORDIC_W'(g_z);
      g_side_q <= f_side_q;
    end
  end

  assign ctl_o  = g_ctl_q;
  assign z_o    = g_z_q;
  assign side_o = g_side_q;

endmodule

// ===== sv/pra_cordic.sv =====
// ----------------------------------------------------------------------------
// pra_cordic: pipelined rotation-mode cordic
// one micro-rotation per stage, then sign fix and clamp to [-1, 1] in q2.30
// ----------------------------------------------------------------------------
module pra_cordic import pra_pkg::*; #(
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  ctl_t                       ctl_i,
  input  logic signed [CORDIC_W-1:0] z_i,
  input  side_t                      side_i,
  output logic                       valid_o,
  output logic signed [TRIG_W-1:0]   cos_o,
  output logic signed [TRIG_W-1:0]   sin_o,
  output side_t                      side_o
);

  logic signed [CORDIC_W-1:0] x_q [CORDIC_STAGES];
  logic signed [CORDIC_W-1:0] y_q [CORDIC_STAGES];
  logic signed [CORDIC_W-1:0] z_q [CORDIC_STAGES];
  ctl_t                       ctl_q [CORDIC_STAGES];
  side_t                      side_q [CORDIC_STAGES];

  logic                       h_valid_q;
  logic signed [TRIG_W-1:0]   h_cos_q;
  logic signed [TRIG_W-1:0]   h_sin_q;
  side_t                      h_side_q;

  function automatic logic signed [TRIG_W-1:0] clamp_trig(
    input logic signed [CORDIC_W-1:0] v,
    input logic                       flip
  );
    logic signed [CORDIC_W-1:0] w;
    w = flip ? -v : v;
    if (w > ONE_Q30) begin
      return TRIG_W'(ONE_Q30);
    end else if (w < -ONE_Q30) begin
      return TRIG_W'(-ONE_Q30);
    end
    return TRIG_W'(w);
  endfunction

  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_stage
    logic signed [CORDIC_W-1:0] x_prev, y_prev, z_prev;
    logic signed [CORDIC_W-1:0] x_d, y_d, z_d;
    ctl_t                       ctl_prev;
    side_t                      side_prev;

    if (k == 0) begin : g_first
      assign x_prev    = GAIN_Q30;
      assign y_prev    = '0;
      assign z_prev    = z_i;
      assign ctl_prev  = ctl_i;
      assign side_prev = side_i;
    end else begin : g_next
      assign x_prev    = x_q[k-1];
      assign y_prev    = y_q[k-1];
      assign z_prev    = z_q[k-1];
      assign ctl_prev  = ctl_q[k-1];
      assign side_prev = side_q[k-1];
    end

    // rotate toward zero residual angle
    always_comb begin
      if (!z_prev[CORDIC_W-1]) begin
        x_d = x_prev - (y_prev >>> k);
        y_d = y_prev + (x_prev >>> k);
        z_d = z_prev - CORDIC_W'(ATAN_PHASE[k]);
      end else begin
        x_d = x_prev + (y_prev >>> k);
        y_d = y_prev - (x_prev >>> k);
        z_d = z_prev + CORDIC_W'(ATAN_PHASE[k]);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ctl_q[k] <= '0;
      end else if (en_i) begin
        ctl_q[k] <= ctl_prev;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[k]    <= x_d;
        y_q[k]    <= y_d;
        z_q[k]    <= z_d;
        side_q[k] <= side_prev;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_valid_q <= 1'b0;
    end else if (en_i) begin
      h_valid_q <= ctl_q[CORDIC_STAGES-1].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      h_cos_q  <= clamp_trig(x_q[CORDIC_STAGES-1], ctl_q[CORDIC_STAGES-1].neg);
      h_sin_q  <= clamp_trig(y_q[CORDIC_STAGES-1], ctl_q[CORDIC_STAGES-1].neg);
      h_side_q <= side_q[CORDIC_STAGES-1];
    end
  end

  assign valid_o = h_valid_q;
  assign cos_o   = h_cos_q;
  assign sin_o   = h_sin_q;
  assign side_o  = h_side_q;

endmodule

// ===== sv/pra_rotate.sv =====
// ----------------------------------------------------------------------------
// pra_rotate: offset rotation and center add
// products, rounded sums, then center add with saturation to 32 bits
// ----------------------------------------------------------------------------
module pra_rotate import pra_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  logic signed [TRIG_W-1:0] cos_i,
  input  logic signed [TRIG_W-1:0] sin_i,
  input  side_t                    side_i,
  output logic                     valid_o,
  output logic signed [DATA_W-1:0] rx_o,
  output logic signed [DATA_W-1:0] ry_o
);

  localparam int unsigned PROD_W = DIFF_W + TRIG_W;
  localparam int unsigned SUM_W  = PROD_W + 1;
  localparam int unsigned T_W    = SUM_W - TRIG_FRAC;
  localparam int unsigned W_W    = T_W + 1;
  localparam logic signed [SUM_W-1:0] ROUND  = SUM_W'(64'sd1 <<< (TRIG_FRAC - 1));
  localparam logic signed [W_W-1:0]   SAT_HI = W_W'(64'sd2147483647);
  localparam logic signed [W_W-1:0]   SAT_LO = W_W'(-64'sd2147483648);

  // r1: products
  logic                      r1_valid_q;
  logic signed [PROD_W-1:0]  r1_xc_q, r1_ys_q, r1_xs_q, r1_yc_q;
  logic signed [DATA_W-1:0]  r1_cx_q, r1_cy_q;
  // r2: rounded rotated offset
  logic                      r2_valid_q;
  logic signed [T_W-1:0]     r2_tx_q, r2_ty_q;
  logic signed [DATA_W-1:0]  r2_cx_q, r2_cy_q;
  logic signed [SUM_W-1:0]   r2_sx, r2_sy;
  // r3: result
  logic                      r3_valid_q;
  logic signed [DATA_W-1:0]  r3_x_q, r3_y_q;
  logic signed [W_W-1:0]     r3_wx, r3_wy;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [W_W-1:0] v);
    if (v > SAT_HI) begin
      return DATA_W'(SAT_HI);
    end else if (v < SAT_LO) begin
      return DATA_W'(SAT_LO);
    end
    return DATA_W'(v);
  endfunction

  assign r2_sx = SUM_W'(r1_xc_q) - SUM_W'(r1_ys_q) + ROUND;
  assign r2_sy = SUM_W'(r1_xs_q) + SUM_W'(r1_yc_q) + ROUND;

  assign r3_wx = W_W'(r2_cx_q) + W_W'(r2_tx_q);
  assign r3_wy = W_W'(r2_cy_q) + W_W'(r2_ty_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r1_valid_q <= 1'b0;
      r2_valid_q <= 1'b0;
      r3_valid_q <= 1'b0;
    end else if (en_i) begin
      r1_valid_q <= valid_i;
      r2_valid_q <= r1_valid_q;
      r3_valid_q <= r2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r1_xc_q <= PROD_W'(side_i.dx) * PROD_W'(cos_i);
      r1_ys_q <= PROD_W'(side_i.dy) * PROD_W'(sin_i);
      r1_xs_q <= PROD_W'(side_i.dx) * PROD_W'(sin_i);
      r1_yc_q <= PROD_W'(side_i.dy) * PROD_W'(cos_i);
      r1_cx_q <= side_i.cx;
      r1_cy_q <= side_i.cy;

      r2_tx_q <= T_W'(r2_sx >>> TRIG_FRAC);
      r2_ty_q <= T_W'(r2_sy >>> TRIG_FRAC);
      r2_cx_q <= r1_cx_q;
      r2_cy_q <= r1_cy_q;

      r3_x_q <= sat32(r3_wx);
      r3_y_q <= sat32(r3_wy);
    end
  end

  assign valid_o = r3_valid_q;
  assign rx_o    = r3_x_q;
  assign ry_o    = r3_y_q;

endmodule

// ===== sv/point_rotate_about_origin.sv =====
// throughput: one transaction per cycle, set by the fully pipelined phase, cordic and
//   multiply stages; every stage advances each cycle unless the output skid slot is full
// reset: asynchronous, active low; clears the valid bits of every stage and the output
//   and skid registers; no other state, no clearing pass
// ----------------------------------------------------------------------------
// point_rotate_about_origin: rotate a 2d point about a center by an angle
// q16.16 coordinates and degrees, cordic sine and cosine, saturated result
// ----------------------------------------------------------------------------
module point_rotate_about_origin import pra_pkg::*; #(
  parameter int unsigned CORDIC_STAGES = 16,
  parameter int unsigned FRAC_BITS     = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // input channel
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic signed [DATA_W-1:0] point_x_i,
  input  logic signed [DATA_W-1:0] point_y_i,
  input  logic signed [DATA_W-1:0] center_x_i,
  input  logic signed [DATA_W-1:0] center_y_i,
  input  logic signed [DATA_W-1:0] angle_deg_i,
  // output channel
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [DATA_W-1:0] rotated_x_o,
  output logic signed [DATA_W-1:0] rotated_y_o
);

  // pipeline advance, held only while the skid slot holds a transaction
  logic                     pipe_en;
  logic                     in_accept;
  side_t                    in_side;

  ctl_t                       ph_ctl;
  logic signed [CORDIC_W-1:0] ph_z;
  side_t                      ph_side;

  logic                     cd_valid;
  logic signed [TRIG_W-1:0] cd_cos, cd_sin;
  side_t                    cd_side;

  logic                     rot_valid;
  logic signed [DATA_W-1:0] rot_x, rot_y;

  // output register plus one skid slot
  logic                     out_valid_q, out_valid_d;
  logic                     skid_valid_q, skid_valid_d;
  logic signed [DATA_W-1:0] out_x_q, out_y_q;
  logic signed [DATA_W-1:0] skid_x_q, skid_y_q;
  logic                     load_out_pipe, load_out_skid, load_skid;

  assign pipe_en   = !skid_valid_q;
  assign in_accept = in_valid_i && pipe_en;

  // offset from the center is exact in 33 bits
  assign in_side.dx = DIFF_W'(point_x_i) - DIFF_W'(center_x_i);
  assign in_side.dy = DIFF_W'(point_y_i) - DIFF_W'(center_y_i);
  assign in_side.cx = center_x_i;
  assign in_side.cy = center_y_i;

  // angle reduction and quadrant fold
  pra_phase #(
    .FRAC_BITS (FRAC_BITS)
  ) u_phase (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (pipe_en),
    .valid_i     (in_accept),
    .angle_deg_i (angle_deg_i),
    .side_i      (in_side),
    .ctl_o       (ph_ctl),
    .z_o         (ph_z),
    .side_o      (ph_side)
  );

  // cos and sin in q2.30
  pra_cordic #(
    .CORDIC_STAGES (CORDIC_STAGES)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .ctl_i   (ph_ctl),
    .z_i     (ph_z),
    .side_i  (ph_side),
    .valid_o (cd_valid),
    .cos_o   (cd_cos),
    .sin_o   (cd_sin),
    .side_o  (cd_side)
  );

  // rotate the offset and add the center back
  pra_rotate u_rotate (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (cd_valid),
    .cos_i   (cd_cos),
    .sin_i   (cd_sin),
    .side_i  (cd_side),
    .valid_o (rot_valid),
    .rx_o    (rot_x),
    .ry_o    (rot_y)
  );

  // while the skid slot is empty the pipeline always moves, so a finished
  // transaction lands in the output register or, if that one is stalled, in skid
  always_comb begin
    out_valid_d   = out_valid_q;
    skid_valid_d  = skid_valid_q;
    load_out_pipe = 1'b0;
    load_out_skid = 1'b0;
    load_skid     = 1'b0;
    if (skid_valid_q) begin
      if (!out_stall_i) begin
        skid_valid_d  = 1'b0;
        load_out_skid = 1'b1;
      end
    end else if (!out_valid_q || !out_stall_i) begin
      out_valid_d   = rot_valid;
      load_out_pipe = rot_valid;
    end else if (rot_valid) begin
      skid_valid_d = 1'b1;
      load_skid    = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out_pipe) begin
      out_x_q <= rot_x;
      out_y_q <= rot_y;
    end else if (load_out_skid) begin
      out_x_q <= skid_x_q;
      out_y_q <= skid_y_q;
    end
    if (load_skid) begin
      skid_x_q <= rot_x;
      skid_y_q <= rot_y;
    end
  end

  assign in_stall_o  = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign rotated_x_o = out_x_q;
  assign rotated_y_o = out_y_q;

endmodule

// ===== sv/pra_checker.sv =====
// ----------------------------------------------------------------------------
// pra_checker: port level checks of the point rotation block
// output hold behavior and input stall tied to the output skid slot
// ----------------------------------------------------------------------------
module pra_checker import pra_pkg::*; (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_stall_o,
  input logic                     out_valid_o,
  input logic                     out_stall_i,
  input logic signed [DATA_W-1:0] rotated_x_o,
  input logic signed [DATA_W-1:0] rotated_y_o
);

  // a stalled result transaction stays and holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(rotated_x_o) && $stable(rotated_y_o)))
    else $error("stalled result transaction changed or dropped");

  // input stall only with a result waiting in front of it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled without a pending result");

  // input stall starts only after a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(out_valid_o && out_stall_i))
    else $error("input stall raised without output back pressure");

  // once the output drains, the input stall clears the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_stall_o && !out_stall_i) |=> !in_stall_o)
    else $error("input stall held after output drained");

endmodule

bind point_rotate_about_origin pra_checker u_pra_checker (.*);

// ===== tb/point_rotate_about_origin_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_rotate_about_origin_tb: self-checking bench for the point rotation block
// feeds directed corner points and random points, angles and centers through
// the valid/stall channels, predicts every rotated point in q16.16 with a
// cycle-free cordic model and compares each result transaction in order
// ----------------------------------------------------------------------------
module point_rotate_about_origin_tb;
  import pra_pkg::*;

  localparam int FRAC         = 16;          // fractional bits of every field
  localparam int STAGES       = 16;          // cordic iterations of the dut
  localparam int ONE_FX       = 1 << FRAC;   // 1.0 in q16.16
  localparam int DEG90        = 90 * ONE_FX;
  localparam int TURN_FX      = 360 * ONE_FX;
  localparam int COORD_SPAN   = 1000 * ONE_FX;
  localparam int RAND_ITEMS   = 630;
  localparam int HOLD_AT      = 250;         // random item that triggers the long hold
  localparam int PAUSE_AT     = 420;         // random item before which the sender drains
  localparam int HOLD_CYCLES  = 300;
  localparam int TAIL_CYCLES  = 40;          // quiet stretch after the last result, before the summary
  localparam int ERR_SHOWN    = 10;

  typedef struct {
    logic signed [DATA_W-1:0] px;
    logic signed [DATA_W-1:0] py;
    logic signed [DATA_W-1:0] cx;
    logic signed [DATA_W-1:0] cy;
    logic signed [DATA_W-1:0] ang;
  } item_t;

  typedef struct {
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] y;
  } xy_t;

  // --------------------------------------------------------------------------
  // scoreboard: predicts each rotated point and checks results in order
  // --------------------------------------------------------------------------
  class rotation_scoreboard;
    xy_t         pending_rot[$];
    int unsigned noted     = 0;
    int unsigned matched   = 0;
    int unsigned errors    = 0;
    int unsigned folded    = 0;   // angles past a quarter turn either way
    int unsigned saturated = 0;   // predictions clipped at the q16.16 range

    function automatic longint clip(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // origin + R(angle) * (point - origin), cordic sine and cosine in q2.30
    function automatic xy_t rotate_about_center(item_t it);
      longint turn, r, ph, p, x, y, z, xs, ys, dx, dy, sx, sy, one;
      logic signed [31:0] ph_w;
      bit   fold;
      xy_t  res;
      one  = ONE_Q30;
      turn = longint'(360) << FRAC;
      // reduce to [0, 360) degrees, then to a 32-bit phase rounded half up
      r = longint'(it.ang) % turn;
      if (r < 0) r += turn;
      ph   = ((r << (32 - FRAC)) + 180) / 360;
      ph_w = ph[31:0];
      p    = ph_w;
      fold = 1'b0;
      // fold into +-90 degrees, negate cos and sin afterwards
      if (p > longint'(QUARTER_POS)) begin
        p    = p - (longint'(1) << 31);
        fold = 1'b1;
      end else if (p < longint'(QUARTER_NEG)) begin
        p    = p + (longint'(1) << 31);
        fold = 1'b1;
      end
      if (fold) folded++;
      x = GAIN_Q30;
      y = 0;
      z = p;
      for (int i = 0; i < STAGES; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (z >= 0) begin
          x = x - ys;
          y = y + xs;
          z = z - longint'(ATAN_PHASE[i]);
        end else begin
          x = x + ys;
          y = y - xs;
          z = z + longint'(ATAN_PHASE[i]);
        end
      end
      if (fold) begin
        x = -x;
        y = -y;
      end
      x  = clip(x, -one, one);
      y  = clip(y, -one, one);
      dx = longint'(it.px) - longint'(it.cx);
      dy = longint'(it.py) - longint'(it.cy);
      sx = ((dx * x - dy * y + (one >>> 1)) >>> TRIG_FRAC) + longint'(it.cx);
      sy = ((dx * y + dy * x + (one >>> 1)) >>> TRIG_FRAC) + longint'(it.cy);
      if (sx != clip(sx, -(longint'(1) << 31), (longint'(1) << 31) - 1) ||
          sy != clip(sy, -(longint'(1) << 31), (longint'(1) << 31) - 1)) begin
        saturated++;
      end
      sx    = clip(sx, -(longint'(1) << 31), (longint'(1) << 31) - 1);
      sy    = clip(sy, -(longint'(1) << 31), (longint'(1) << 31) - 1);
      res.x = sx[31:0];
      res.y = sy[31:0];
      return res;
    endfunction

    function void note_point(item_t it);
      pending_rot.push_back(rotate_about_center(it));
      noted++;
    endfunction

    function void check_result(logic signed [DATA_W-1:0] rx, logic signed [DATA_W-1:0] ry);
      xy_t want;
      if (pending_rot.size() == 0) begin
        if (errors < ERR_SHOWN)
          $display("unexpected result x=%h y=%h with nothing pending", rx, ry);
        errors++;
        return;
      end
      want = pending_rot.pop_front();
      if (rx !== want.x || ry !== want.y) begin
        if (errors < ERR_SHOWN)
          $display("mismatch on result %0d: expected x=%h y=%h, got x=%h y=%h",
                   matched + errors, want.x, want.y, rx, ry);
        errors++;
      end else begin
        matched++;
      end
    endfunction

    function int unsigned pending();
      return pending_rot.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // clock, reset and dut
  // --------------------------------------------------------------------------
  logic                     clk_i       = 1'b0;
  logic                     rst_ni      = 1'b0;
  logic                     in_valid_i  = 1'b0;
  logic                     in_stall_o;
  logic signed [DATA_W-1:0] point_x_i   = '0;
  logic signed [DATA_W-1:0] point_y_i   = '0;
  logic signed [DATA_W-1:0] center_x_i  = '0;
  logic signed [DATA_W-1:0] center_y_i  = '0;
  logic signed [DATA_W-1:0] angle_deg_i = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic signed [DATA_W-1:0] rotated_x_o;
  logic signed [DATA_W-1:0] rotated_y_o;

  rotation_scoreboard sb = new();

  int unsigned in_count   = 0;    // accepted input transactions
  int unsigned holds_done = 0;    // long output hold-offs carried out
  bit          hold_req   = 1'b0; // sender asks the receiver for a long hold-off

  always #5 clk_i = ~clk_i;

  point_rotate_about_origin dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .point_x_i   (point_x_i),
    .point_y_i   (point_y_i),
    .center_x_i  (center_x_i),
    .center_y_i  (center_y_i),
    .angle_deg_i (angle_deg_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .rotated_x_o (rotated_x_o),
    .rotated_y_o (rotated_y_o)
  );

  // --------------------------------------------------------------------------
  // monitor: both channels sampled at the rising edge, before any update lands
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    item_t seen;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      seen.px  = point_x_i;
      seen.py  = point_y_i;
      seen.cx  = center_x_i;
      seen.cy  = center_y_i;
      seen.ang = angle_deg_i;
      sb.note_point(seen);
      in_count++;
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_result(rotated_x_o, rotated_y_o);
    end
  end

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  function automatic item_t mk(int px, int py, int cx, int cy, int ang);
    item_t it;
    it.px  = px;
    it.py  = py;
    it.cx  = cx;
    it.cy  = cy;
    it.ang = ang;
    return it;
  endfunction

  // full-range, moderate, near the positive edge and near the negative edge
  function automatic logic signed [DATA_W-1:0] rand_coord();
    logic signed [DATA_W-1:0] v;
    case ($urandom_range(0, 4))
      0, 1:    v = $urandom();
      2:       v = $signed($urandom_range(0, 2 * COORD_SPAN)) - COORD_SPAN;
      3:       v = 32'h7FFF_0000 + $urandom_range(0, 32'hFFFF);
      default: v = 32'h8000_0000 + $urandom_range(0, 32'hFFFF);
    endcase
    return v;
  endfunction

  function automatic logic signed [DATA_W-1:0] rand_angle();
    logic signed [DATA_W-1:0] v;
    case ($urandom_range(0, 4))
      0:       v = $urandom();
      1:       v = ($signed($urandom_range(0, 2160)) - 1080) * ONE_FX;
      2:       v = ($signed($urandom_range(0, 16)) - 8) * DEG90;
      // a few lsb either side of a quarter-turn boundary, where the fold flips
      3:       v = ($signed($urandom_range(0, 8)) - 4) * DEG90 +
                   $signed($urandom_range(0, 64)) - 32;
      default: v = $signed($urandom_range(0, 2 * TURN_FX)) - TURN_FX;
    endcase
    return v;
  endfunction

  function automatic item_t rand_item();
    item_t it;
    it.px  = rand_coord();
    it.py  = rand_coord();
    it.cx  = rand_coord();
    it.cy  = rand_coord();
    it.ang = rand_angle();
    // point on the center now and then: the result must be the center itself
    if ($urandom_range(0, 15) == 0) begin
      it.cx = it.px;
      it.cy = it.py;
    end
    return it;
  endfunction

  // offer one transaction at a falling edge and hold it until taken;
  // returns at the falling edge after the accepting rising edge
  task automatic send_item(item_t it);
    int unsigned n0;
    in_valid_i  = 1'b1;
    point_x_i   = it.px;
    point_y_i   = it.py;
    center_x_i  = it.cx;
    center_y_i  = it.cy;
    angle_deg_i = it.ang;
    n0 = in_count;
    do @(negedge clk_i); while (in_count == n0);
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(negedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // receiver: random stall patterns over random-length stretches, plus one long hold
  // --------------------------------------------------------------------------
  initial begin : receiver
    int stall_mode;
    int mode_left;
    int hold_left;
    int tick;
    stall_mode = 0;
    mode_left  = 0;
    hold_left  = 0;
    tick       = 0;
    forever begin
      @(negedge clk_i);
      tick++;
      if (hold_left > 0) begin
        // long hold-off, the pipeline and skid fill up and input stalls
        hold_left--;
        out_stall_i = 1'b1;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        holds_done++;
        hold_left = HOLD_CYCLES - 1;
        out_stall_i = 1'b1;
      end else begin
        if (mode_left == 0) begin
          stall_mode = $urandom_range(0, 3);
          mode_left  = $urandom_range(16, 96);
        end
        mode_left--;
        case (stall_mode)
          0:       out_stall_i = 1'b0;                          // free-running stretch
          1:       out_stall_i = ($urandom_range(0, 4) == 0);   // light stalls
          2:       out_stall_i = ($urandom_range(0, 3) != 0);   // heavy stalls
          default: out_stall_i = ((tick % 5) < 2);              // periodic stalls
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // sender: reset, directed corners, then random bursts with random gaps
  // --------------------------------------------------------------------------
  initial begin : sender
    item_t corner_q[$];
    int    k;
    int    burst;
    int    gap;

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(negedge clk_i);

    // zero input, unit point at each quarter turn and at whole turns
    corner_q.push_back(mk(0, 0, 0, 0, 0));
    corner_q.push_back(mk(ONE_FX, 0, 0, 0, 0));
    corner_q.push_back(mk(ONE_FX, 0, 0, 0, DEG90));
    corner_q.push_back(mk(ONE_FX, 0, 0, 0, 2 * DEG90));
    corner_q.push_back(mk(ONE_FX, 0, 0, 0, 3 * DEG90));
    corner_q.push_back(mk(ONE_FX, 0, 0, 0, -DEG90));
    corner_q.push_back(mk(ONE_FX, 0, 0, 0, TURN_FX));
    corner_q.push_back(mk(ONE_FX, 0, 0, 0, -2 * TURN_FX));
    // general point about an off-origin center at 45 degrees
    corner_q.push_back(mk(10 * ONE_FX, 5 * ONE_FX, 3 * ONE_FX, -2 * ONE_FX, DEG90 / 2));
    // extreme angles, reduced modulo a full turn
    corner_q.push_back(mk(100 * ONE_FX, 0, 0, 0, 32'h7FFF_FFFF));
    corner_q.push_back(mk(100 * ONE_FX, 0, 0, 0, 32'h8000_0000));
    // one lsb past the quarter turn either way, the fold boundary, and one lsb short of a half turn
    corner_q.push_back(mk(50 * ONE_FX, 7 * ONE_FX, 0, 0, DEG90 + 1));
    corner_q.push_back(mk(50 * ONE_FX, 7 * ONE_FX, 0, 0, -DEG90 - 1));
    corner_q.push_back(mk(50 * ONE_FX, 7 * ONE_FX, 0, 0, 2 * DEG90 - 1));
    // widest offsets: exact at zero degrees, saturating at a half turn and at a quarter turn
    corner_q.push_back(mk(32'h7FFF_FFFF, 0, 32'h8000_0000, 0, 0));
    corner_q.push_back(mk(32'h7FFF_FFFF, 0, 32'h8000_0000, 0, 2 * DEG90));
    corner_q.push_back(mk(32'h8000_0000, 0, 32'h7FFF_FFFF, 0, 2 * DEG90));
    corner_q.push_back(mk(0, 32'h7FFF_FFFF, 0, 32'h8000_0000, DEG90));
    // point on the center at an odd angle
    corner_q.push_back(mk(32'h1234_5678, -32'sh0765_4321, 32'h1234_5678, -32'sh0765_4321,
                          123 * ONE_FX + 17));
    // smallest nonzero angles on a large point
    corner_q.push_back(mk(30000 * ONE_FX, -20000 * ONE_FX, 0, 0, 1));
    corner_q.push_back(mk(30000 * ONE_FX, -20000 * ONE_FX, 0, 0, -1));
    // diagonal corners at 45 degrees, saturating high and low
    corner_q.push_back(mk(32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, DEG90 / 2));
    corner_q.push_back(mk(32'h8000_0000, 32'h8000_0000, 0, 0, DEG90 / 2));

    foreach (corner_q[i]) begin
      send_item(corner_q[i]);
      if ($urandom_range(0, 2) == 0) begin
        in_valid_i = 1'b0;
        repeat ($urandom_range(1, 4)) @(negedge clk_i);
      end
    end
    // sender pause until every corner result is back
    in_valid_i = 1'b0;
    wait_drained();

    k = 0;
    while (k < RAND_ITEMS) begin
      burst = $urandom_range(1, 24);
      for (int b = 0; b < burst && k < RAND_ITEMS; b++) begin
        // receiver holds off for a long stretch while the sender keeps offering
        if (k == HOLD_AT) hold_req = 1'b1;
        // sender goes quiet until the pipeline is empty, then resumes
        if (k == PAUSE_AT) begin
          in_valid_i = 1'b0;
          wait_drained();
        end
        send_item(rand_item());
        k++;
      end
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid_i = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    in_valid_i = 1'b0;

    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk_i);

    $display("covered %0d points (%0d with the angle folded past a quarter turn, %0d saturated),",
             sb.noted, sb.folded, sb.saturated);
    $display("%0d results matched, %0d errors, %0d long output hold-offs",
             sb.matched, sb.errors, holds_done);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // run limit, far above the slowest correct run
  initial begin : watchdog
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/pra_pkg.sv
sv/pra_phase.sv
sv/pra_cordic.sv
sv/pra_rotate.sv
sv/point_rotate_about_origin.sv
sv/pra_checker.sv
tb/point_rotate_about_origin_tb.sv
